FILE: hdl/tdts_pkg.sv
package tdts_pkg;

   // Command codes carried in the input item's tuser
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_CREATE = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_DELAY  = 3'd3;
   localparam logic [2:0] CMD_YIELD  = 3'd4;
   localparam logic [2:0] CMD_WAKE   = 3'd5;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_WAIT = 2'd2;

   // Register addresses (word index taken from paddr[2])
   localparam logic REG_TICK_WINDOW = 1'b0;

   localparam logic [31:0] TICK_WINDOW_RESET = 32'h8000_0000;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE  = 7'b000_0001,
      S_EXEC  = 7'b000_0010,
      S_DLYW  = 7'b000_0100,
      S_FIND  = 7'b000_1000,
      S_SCAN  = 7'b001_0000,
      S_CHECK = 7'b010_0000,
      S_RESP  = 7'b100_0000
   } state_type;

   // Operands to the shared add/subtract/compare unit
   typedef struct packed {
      logic        sub;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] window;
   } alu_req_type;

   // Results of the shared unit
   typedef struct packed {
      logic [31:0] res;
      logic        borrow;
      logic        due;
   } alu_rsp_type;

endpackage

FILE: hdl/tdts_alu.sv
module tdts_alu (
   input  tdts_pkg::alu_req_type req,
   output tdts_pkg::alu_rsp_type rsp
);

   logic [32:0] sum;

   // Add or subtract, then compare the result against the window
   always_comb begin
      if (req.sub) begin
         sum = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         sum = {1'b0, req.a} + {1'b0, req.b};
      end
      rsp.res    = sum[31:0];
      rsp.borrow = sum[32];
      rsp.due    = (sum[31:0] < req.window);
   end

endmodule

FILE: hdl/tdts_wake_ram.sv
module tdts_wake_ram #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [31:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [31:0]   rdata
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;

   // Write one wake tick, read one with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/tick_delay_task_scheduler_core.sv
// Sequence: tick, wake, and delete without switch pass through the execute and response
// states before rsp_tvalid. Create searches for the first free slot before the response; a
// switch scans the slots, a candidate slot taking a wake RAM read, then subtract/compare.
// Throughput: one item at a time; req_tready is high only while the sequencer is idle.
// Reset (synchronous, active high): tick zero, all slots inactive, idle slot current,
// tick window 0x80000000. Wake ticks are not cleared.
module tick_delay_task_scheduler_core #(
   parameter int TASKS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata fields, low bit up: slot[2:0], amount[34:3], zero fill [39:35]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // req_tuser fields, low bit up: command[2:0]
   input  logic [2:0]  req_tuser,
   // rsp_tdata fields, low bit up: status[1:0], created_slot[4:2], current_task[7:5],
   // switched[8], now[40:9], zero fill [47:41]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam logic [IW-1:0] LAST = IW'(TASKS - 1);
   localparam logic [5:0] TASKS_W = 6'(TASKS);
   localparam logic [5:0] LAST_W  = 6'(TASKS - 1);

   tdts_pkg::state_type state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [2:0]       slot_ff, slot_in;
   logic [31:0]      amount_ff, amount_in;
   logic [31:0]      window_ff, window_in;
   logic [31:0]      sys_ff, sys_in;
   logic [TASKS-1:0] active_ff, active_in;
   logic [IW-1:0]    cur_ff, cur_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [1:0]       status_ff, status_in;
   logic [IW-1:0]    created_ff, created_in;
   logic             switched_ff, switched_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [47:0]      rsp_data_ff, rsp_data_in;

   tdts_pkg::alu_req_type alu_req;
   tdts_pkg::alu_rsp_type alu_rsp;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic [31:0]   ram_rdata;

   logic [31:0]   slot_wide;
   logic [IW-1:0] slot_ix;
   logic [31:0]   cur_wide;
   logic [31:0]   created_wide;
   logic          req_fire;
   logic          csr_write;

   tdts_alu u_alu (
      .req(alu_req),
      .rsp(alu_rsp)
   );

   tdts_wake_ram #(
      .DEPTH(TASKS),
      .AW   (IW)
   ) u_wake_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(idx_ff),
      .rdata(ram_rdata)
   );

   assign req_tready   = (state_ff == tdts_pkg::S_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign csr_pready   = 1'b1;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata   = (csr_paddr[2] == tdts_pkg::REG_TICK_WINDOW) ? window_ff : 32'd0;

   assign slot_wide    = 32'(slot_ff);
   assign slot_ix      = slot_wide[IW-1:0];
   assign cur_wide     = 32'(cur_ff);
   assign created_wide = 32'(created_ff);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      amount_in    = amount_ff;
      window_in    = window_ff;
      sys_in       = sys_ff;
      active_in    = active_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      created_in   = created_ff;
      switched_in  = switched_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff;
      ram_wdata    = sys_ff;
      alu_req.sub    = 1'b1;
      alu_req.a      = sys_ff;
      alu_req.b      = ram_rdata;
      alu_req.window = window_ff;

      // Take a register write
      if (csr_write && (csr_paddr[2] == tdts_pkg::REG_TICK_WINDOW)) begin
         window_in = csr_pwdata;
      end

      unique case (state_ff)
         tdts_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_tuser;
               slot_in     = req_tdata[2:0];
               amount_in   = req_tdata[34:3];
               status_in   = tdts_pkg::STATUS_OK;
               created_in  = '0;
               switched_in = 1'b0;
               idx_in      = '0;
               state_in    = tdts_pkg::S_EXEC;
            end
         end

         tdts_pkg::S_EXEC: begin
            state_in = tdts_pkg::S_RESP;
            unique case (cmd_ff)
               tdts_pkg::CMD_TICK: begin
                  alu_req.sub = 1'b0;
                  alu_req.a   = sys_ff;
                  alu_req.b   = 32'd1;
                  sys_in      = alu_rsp.res;
               end
               tdts_pkg::CMD_CREATE: begin
                  state_in = tdts_pkg::S_FIND;
               end
               tdts_pkg::CMD_DELETE: begin
                  if ({3'b000, slot_ff} < TASKS_W) begin
                     active_in[slot_ix] = 1'b0;
                     if (slot_ix == cur_ff) begin
                        switched_in = 1'b1;
                        state_in    = tdts_pkg::S_SCAN;
                     end
                  end
               end
               tdts_pkg::CMD_DELAY: begin
                  // window - amount borrows when the delay is too long
                  alu_req.sub = 1'b1;
                  alu_req.a   = window_ff;
                  alu_req.b   = amount_ff;
                  if (alu_rsp.borrow) begin
                     status_in = tdts_pkg::STATUS_BAD_WAIT;
                  end else begin
                     state_in = tdts_pkg::S_DLYW;
                  end
               end
               tdts_pkg::CMD_YIELD: begin
                  switched_in = 1'b1;
                  state_in    = tdts_pkg::S_SCAN;
               end
               tdts_pkg::CMD_WAKE: begin
                  if ({3'b000, slot_ff} < LAST_W) begin
                     active_in[slot_ix] = 1'b1;
                     ram_we    = 1'b1;
                     ram_waddr = slot_ix;
                     ram_wdata = sys_ff;
                  end
               end
               default: begin
               end
            endcase
         end

         tdts_pkg::S_DLYW: begin
            // Store wake tick of the current slot, then switch
            alu_req.sub = 1'b0;
            alu_req.a   = sys_ff;
            alu_req.b   = amount_ff;
            ram_we      = 1'b1;
            ram_waddr   = cur_ff;
            ram_wdata   = alu_rsp.res;
            switched_in = 1'b1;
            state_in    = tdts_pkg::S_SCAN;
         end

         tdts_pkg::S_FIND: begin
            priority if (idx_ff == LAST) begin
               status_in = tdts_pkg::STATUS_FULL;
               state_in  = tdts_pkg::S_RESP;
            end else if (!active_ff[idx_ff]) begin
               active_in[idx_ff] = 1'b1;
               ram_we     = 1'b1;
               ram_waddr  = idx_ff;
               ram_wdata  = sys_ff;
               created_in = idx_ff;
               state_in   = tdts_pkg::S_RESP;
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end

         tdts_pkg::S_SCAN: begin
            // Skip current and inactive slots; a candidate reads its wake tick
            priority if (idx_ff == LAST) begin
               cur_in   = idx_ff;
               state_in = tdts_pkg::S_RESP;
            end else if ((idx_ff == cur_ff) || !active_ff[idx_ff]) begin
               idx_in = IW'(idx_ff + 1'b1);
            end else begin
               state_in = tdts_pkg::S_CHECK;
            end
         end

         tdts_pkg::S_CHECK: begin
            // Due when (now - wake) wraps below the window
            alu_req.sub = 1'b1;
            alu_req.a   = sys_ff;
            alu_req.b   = ram_rdata;
            if (alu_rsp.due) begin
               cur_in   = idx_ff;
               state_in = tdts_pkg::S_RESP;
            end else begin
               idx_in   = IW'(idx_ff + 1'b1);
               state_in = tdts_pkg::S_SCAN;
            end
         end

         tdts_pkg::S_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, sys_ff, switched_ff, cur_wide[2:0],
                               created_wide[2:0], status_ff};
               state_in     = tdts_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = tdts_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdts_pkg::S_IDLE;
         window_ff    <= tdts_pkg::TICK_WINDOW_RESET;
         sys_ff       <= 32'd0;
         active_ff    <= '0;
         cur_ff       <= LAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         sys_ff       <= sys_in;
         active_ff    <= active_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      amount_ff   <= amount_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      created_ff  <= created_in;
      switched_ff <= switched_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The idle slot never becomes active
   a_idle_inactive : assert property (@(posedge clock) disable iff (reset)
      !active_ff[TASKS-1])
      else $error("idle slot marked active");

   // An accepted item makes the block busy
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != tdts_pkg::S_IDLE))
      else $error("block still idle after accepting an item");

   // A candidate check always follows a wake RAM read issued in the scan
   a_check_after_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdts_pkg::S_CHECK) |-> ($past(state_ff) == tdts_pkg::S_SCAN))
      else $error("slot check without a preceding read");

   // A new result appears only from the response step
   a_rsp_from_resp : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tdts_pkg::S_RESP))
      else $error("result raised outside the response step");

endmodule

FILE: sim/tick_delay_task_scheduler_checker.sv
`timescale 1ns / 100ps

module tick_delay_task_scheduler_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          errors,
   output int          outstanding
);

   localparam int TASKS     = 8;
   localparam int IDLE_SLOT = TASKS - 1;

   // One result item, first field in the highest bits
   typedef struct packed {
      logic [31:0] now;
      logic        switched;
      logic [2:0]  current_task;
      logic [2:0]  created_slot;
      logic [1:0]  status;
   } sched_result_type;

   // Scheduler state as predicted
   logic [31:0]      window;
   logic [31:0]      tick_count;
   logic [31:0]      wake_at [TASKS];
   logic [TASKS-1:0] task_live;
   logic [2:0]       running;

   sched_result_type pending_results [$];
   sched_result_type got;
   sched_result_type want;

   initial errors = 0;
   initial outstanding = 0;

   task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                input logic [31:0] wanted);
      $display("%0t sched check: %s got %0h want %0h", $realtime, what, seen, wanted);
      errors = errors + 1;
   endtask

   // Lowest active, due, non-current slot; idle if none
   function automatic logic [2:0] next_task();
      logic [31:0] age;
      for (int i = 0; i < IDLE_SLOT; i++) begin
         age = tick_count - wake_at[i];
         if (i != int'(running) && task_live[i] && age < window)
            return i[2:0];
      end
      return IDLE_SLOT[2:0];
   endfunction

   // Apply one command to the predicted state and build its result
   function automatic sched_result_type schedule_command(input logic [2:0] cmd,
                                                         input logic [2:0] slot,
                                                         input logic [31:0] amount);
      sched_result_type r;
      int               free_slot;
      r = '0;
      unique case (cmd)
         tdts_pkg::CMD_TICK: tick_count = tick_count + 32'd1;
         tdts_pkg::CMD_CREATE: begin
            free_slot = 0;
            while (free_slot < IDLE_SLOT && task_live[free_slot])
               free_slot++;
            if (free_slot == IDLE_SLOT) begin
               r.status = tdts_pkg::STATUS_FULL;
            end else begin
               wake_at[free_slot]   = tick_count;
               task_live[free_slot] = 1'b1;
               r.created_slot       = free_slot[2:0];
            end
         end
         tdts_pkg::CMD_DELETE: begin
            task_live[slot] = 1'b0;
            if (slot == running) begin
               running    = next_task();
               r.switched = 1'b1;
            end
         end
         tdts_pkg::CMD_DELAY: begin
            if (amount > window) begin
               r.status = tdts_pkg::STATUS_BAD_WAIT;
            end else begin
               wake_at[running] = tick_count + amount;
               running          = next_task();
               r.switched       = 1'b1;
            end
         end
         tdts_pkg::CMD_YIELD: begin
            running    = next_task();
            r.switched = 1'b1;
         end
         tdts_pkg::CMD_WAKE: begin
            if (int'(slot) < IDLE_SLOT) begin
               task_live[slot] = 1'b1;
               wake_at[slot]   = tick_count;
            end
         end
         default: ;
      endcase
      r.current_task = running;
      r.now          = tick_count;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window      = tdts_pkg::TICK_WINDOW_RESET;
         tick_count  = '0;
         task_live   = '0;
         running     = IDLE_SLOT[2:0];
         for (int i = 0; i < TASKS; i++)
            wake_at[i] = '0;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         // Track register writes, check reads
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == tdts_pkg::REG_TICK_WINDOW)
                  window = csr_pwdata;
            end else if (csr_prdata !== window) begin
               flag_mismatch("tick_window readback", csr_prdata, window);
            end
         end

         // Compare each result item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch("result with nothing pending", rsp_tdata[31:0], '0);
            end else begin
               want = pending_results.pop_front();
               got  = sched_result_type'(rsp_tdata[40:0]);
               if (got.status !== want.status)
                  flag_mismatch("status", got.status, want.status);
               if (got.created_slot !== want.created_slot)
                  flag_mismatch("created_slot", got.created_slot, want.created_slot);
               if (got.current_task !== want.current_task)
                  flag_mismatch("current_task", got.current_task, want.current_task);
               if (got.switched !== want.switched)
                  flag_mismatch("switched", got.switched, want.switched);
               if (got.now !== want.now)
                  flag_mismatch("now", got.now, want.now);
            end
         end

         // Predict the result of each accepted command
         if (req_tvalid && req_tready)
            pending_results.push_back(schedule_command(req_tuser, req_tdata[2:0],
                                                       req_tdata[34:3]));
         outstanding <= pending_results.size();
      end
   end

endmodule

FILE: sim/tb_tick_delay_task_scheduler_core.sv
`timescale 1ns / 100ps

module tb_tick_delay_task_scheduler_core;

   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 65;
   localparam int LONG_STALL   = 120;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // fields, low bit up: slot[2:0], amount[34:3], zero fill [39:35]
   logic [39:0] req_tdata = '0;
   // fields, low bit up: command[2:0]
   logic [2:0]  req_tuser = tdts_pkg::CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // fields, low bit up: status[1:0], created_slot[4:2], current_task[7:5],
   // switched[8], now[40:9], zero fill [47:41]
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          outstanding;

   // Stimulus controls
   int          send_gap_pct = 0;
   int          rsp_gap_pct = 0;
   logic        stall_armed = 1'b0;
   logic        stall_done = 1'b0;
   int          stall_left = 0;
   logic [31:0] window_now = tdts_pkg::TICK_WINDOW_RESET;
   int          items_sent = 0;
   int          results_seen = 0;
   int          quiet_cycles = 0;

   logic [31:0] window_plan [PHASES] = '{32'd16, 32'd1, 32'hFFFF_FFFF, 32'd0,
                                         32'h8000_0000, 32'd7};

   tick_delay_task_scheduler_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tick_delay_task_scheduler_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .errors      (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_armed && !stall_done) begin
         rsp_tready <= 1'b0;
         stall_left <= LONG_STALL;
         stall_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tick_delay_task_scheduler_core: mismatch");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready)
            results_seen <= results_seen + 1;
      end
   end

   // Offer one command; valid stays high after the accept until a gap or a drain
   task automatic send_command(input logic [2:0] cmd, input logic [2:0] slot,
                               input logic [31:0] amount);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'd0, amount, slot};
      do
         @(posedge clock);
      while (!req_tready);
      items_sent <= items_sent + 1;
   endtask

   // Hold the sender until every predicted result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Write tick_window, then read it back
   task automatic write_window(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {tdts_pkg::REG_TICK_WINDOW, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      window_now   = value;
   endtask

   // One random command, weighted toward scheduling activity and small delays
   task automatic send_random_command();
      int          pick;
      logic [2:0]  cmd;
      logic [31:0] amount;
      pick = $urandom_range(99);
      if (pick < 28)      cmd = tdts_pkg::CMD_TICK;
      else if (pick < 40) cmd = tdts_pkg::CMD_CREATE;
      else if (pick < 52) cmd = tdts_pkg::CMD_DELETE;
      else if (pick < 70) cmd = tdts_pkg::CMD_DELAY;
      else if (pick < 84) cmd = tdts_pkg::CMD_YIELD;
      else if (pick < 95) cmd = tdts_pkg::CMD_WAKE;
      else                cmd = 3'($urandom_range(7, 6));
      pick = $urandom_range(99);
      if (pick < 75)      amount = $urandom_range(12);
      else if (pick < 85) amount = window_now + $urandom_range(1);
      else if (pick < 90) amount = window_now - 32'd1;
      else                amount = $urandom();
      send_command(cmd, 3'($urandom_range(7)), amount);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset window, fill the table, delays at and above the window
      send_command(tdts_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF);
      send_command(tdts_pkg::CMD_YIELD, 3'd0, 32'd0);
      repeat (7)
         send_command(tdts_pkg::CMD_CREATE, 3'd0, 32'd0);
      send_command(tdts_pkg::CMD_CREATE, 3'd0, 32'd0);
      send_command(tdts_pkg::CMD_YIELD, 3'd0, 32'd0);
      send_command(tdts_pkg::CMD_DELAY, 3'd0, 32'd3);
      send_command(tdts_pkg::CMD_DELAY, 3'd0, 32'hFFFF_FFFF);
      send_command(tdts_pkg::CMD_DELAY, 3'd0, 32'h8000_0000);
      send_command(tdts_pkg::CMD_DELETE, 3'd2, 32'd0);
      send_command(tdts_pkg::CMD_WAKE, 3'd7, 32'd0);
      send_command(tdts_pkg::CMD_WAKE, 3'd2, 32'd0);
      send_command(3'd6, 3'd5, 32'd0);
      send_command(3'd7, 3'd7, 32'hFFFF_FFFF);
      // empty the table so the idle task ends up deleting itself
      for (int s = 0; s < 7; s++)
         send_command(tdts_pkg::CMD_DELETE, 3'(s), 32'd0);
      send_command(tdts_pkg::CMD_DELETE, 3'd7, 32'd0);

      // Random phases, one window setting each
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_window(window_plan[p]);
         if (p < 2) begin
            send_gap_pct <= 30;
            rsp_gap_pct  <= 73;
         end else if (p < 4) begin
            send_gap_pct <= 73;
            rsp_gap_pct  <= 30;
         end else begin
            send_gap_pct <= 0;
            rsp_gap_pct  <= 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 20)
               stall_armed <= 1'b1;
            if ($urandom_range(49) == 0)
               drain();
            send_random_command();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d commands and %0d results over %0d tick_window settings",
               items_sent, results_seen, PHASES + 1);
      $display("plus full table, long delays, idle self-delete, zero window, %0d-cycle stall",
               LONG_STALL);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tick_delay_task_scheduler_core: match");
      end else begin
         $display("tick_delay_task_scheduler_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/tdts_pkg.sv
hdl/tdts_alu.sv
hdl/tdts_wake_ram.sv
hdl/tick_delay_task_scheduler_core.sv
sim/tick_delay_task_scheduler_checker.sv
sim/tb_tick_delay_task_scheduler_core.sv
